// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL file that carries checks (the top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising aclk edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every rising aclk edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/lfu_pkg.sv =====
// Shared constants and types of the LFU cache policy block.
`timescale 1ns / 1ps

package lfu_pkg;

    localparam int ENTRIES     = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [CAP_W-1:0]       CAP_RESET = CAP_W'(16);

    // Record passed down the cell row: lookup match, victim candidate, first free slot.
    typedef struct packed {
        logic                   hit;
        logic [IDX_W-1:0]       hit_idx;
        logic [IDX_W-1:0]       hit_rank;
        logic [DATA_W-1:0]      hit_value;
        logic                   vic_ok;
        logic [IDX_W-1:0]       vic_idx;
        logic [COUNT_WIDTH-1:0] vic_count;
        logic [IDX_W-1:0]       vic_rank;
        logic [KEY_W-1:0]       vic_key;
        logic                   free_ok;
        logic [IDX_W-1:0]       free_idx;
    } scan_rec_t;

    // Update broadcast to every cell.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  slot;
        logic [IDX_W-1:0]  old_rank;
        logic              shift_all;  // fill of a free slot: every valid entry ages
        logic              load;       // install key/value with count 1
        logic              wr_value;   // put hit: overwrite value
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } upd_cmd_t;

    localparam scan_rec_t REC_INIT = '0;

endpackage

// ===== rtl/lfu_cell.sv =====
// One slot of the store: entry state, scan stage and update logic.
`timescale 1ns / 1ps

module lfu_cell
    import lfu_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [IDX_W-1:0]  cell_idx,
    input  logic [KEY_W-1:0]  lookup_key,
    input  scan_rec_t         rec_in,
    output scan_rec_t         rec_out,
    input  upd_cmd_t          cmd
);

    logic                   valid_reg;
    logic [IDX_W-1:0]       rank_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [DATA_W-1:0]      value_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    scan_rec_t              rec_next;
    logic                   is_me;

    assign is_me = (cmd.slot == cell_idx);

    always_comb begin
        rec_next = rec_in;
        if (!rec_in.hit && valid_reg && (key_reg == lookup_key)) begin
            rec_next.hit       = 1'b1;
            rec_next.hit_idx   = cell_idx;
            rec_next.hit_rank  = rank_reg;
            rec_next.hit_value = value_reg;
        end
        // lowest count wins, older entry on a tie
        if (valid_reg && (!rec_in.vic_ok || (count_reg < rec_in.vic_count) ||
                          ((count_reg == rec_in.vic_count) &&
                           (rank_reg > rec_in.vic_rank)))) begin
            rec_next.vic_ok    = 1'b1;
            rec_next.vic_idx   = cell_idx;
            rec_next.vic_count = count_reg;
            rec_next.vic_rank  = rank_reg;
            rec_next.vic_key   = key_reg;
        end
        if (!rec_in.free_ok && !valid_reg) begin
            rec_next.free_ok  = 1'b1;
            rec_next.free_idx = cell_idx;
        end
    end

    always_ff @(posedge aclk) begin
        rec_out <= rec_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else if (cmd.en) begin
            if (is_me) begin
                rank_reg <= '0;
                if (cmd.load) begin
                    valid_reg <= 1'b1;
                end
            end else if (valid_reg && (cmd.shift_all || (rank_reg < cmd.old_rank))) begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.en && is_me) begin
            if (cmd.load) begin
                key_reg   <= cmd.key;
                value_reg <= cmd.value;
                count_reg <= COUNT_WIDTH'(1);
            end else begin
                if (cmd.wr_value) begin
                    value_reg <= cmd.value;
                end
                if (count_reg != COUNT_MAX) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/lfu_cache_policy_top.sv =====
// Top level of the LFU cache policy block: control, result register, cell row.
// An item is accepted only in ST_IDLE; it then passes ST_SCAN, while the scan record
//   ripples through the whole row of cells, one cell per cycle, and then ST_APPLY,
//   which waits for the result register to be free; no new item is taken until then.
// Reset (aresetn low at a clock edge): store empty, ranks zero, capacity 16,
//   no result pending; ready for an item once reset is released.
`timescale 1ns / 1ps

module lfu_cache_policy_top
    import lfu_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // configuration: cache_capacity
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    // input items
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,   // [31:0] lookup_key, [63:32] write_value
    input  logic [0:0]       s_tuser,   // [0] func (0 get, 1 put)
    // result items
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata,   // [31:0] read_value, [63:32] evicted_key
    output logic [1:0]       m_tuser    // [0] hit, [1] evicted
);

`include "assert_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   scan_cnt_reg;
    logic               op_put_reg;
    logic [KEY_W-1:0]   op_key_reg;
    logic [DATA_W-1:0]  op_value_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [OCC_W-1:0]   occ_reg;
    logic               m_tvalid_reg;
    logic [63:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    scan_rec_t          rec_w [ENTRIES+1];
    scan_rec_t          tail;
    upd_cmd_t           cmd;
    logic               fire;
    logic [CAP_W-1:0]   cap_eff;
    logic               res_hit;
    logic               res_ev;
    logic [DATA_W-1:0]  res_read;
    logic [KEY_W-1:0]   res_ev_key;
    logic               occ_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign rec_w[0] = REC_INIT;
    assign tail     = rec_w[ENTRIES];

    // The row: each cell folds its own slot into the record and passes it on.
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        lfu_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_idx   (IDX_W'(i)),
            .lookup_key (op_key_reg),
            .rec_in     (rec_w[i]),
            .rec_out    (rec_w[i+1]),
            .cmd        (cmd)
        );
    end

    // Decide the access once the record at the row end is settled.
    always_comb begin
        fire       = (state_reg == ST_APPLY) && (!m_tvalid_reg || m_tready);
        cap_eff    = (32'(cap_reg) > 32'(ENTRIES)) ? CAP_W'(ENTRIES) : cap_reg;
        res_hit    = 1'b0;
        res_ev     = 1'b0;
        res_read   = '0;
        res_ev_key = '0;
        occ_inc    = 1'b0;
        cmd        = '0;
        cmd.key    = op_key_reg;
        cmd.value  = op_value_reg;
        if (tail.hit) begin
            res_hit      = 1'b1;
            res_read     = op_put_reg ? '0 : tail.hit_value;
            cmd.en       = fire;
            cmd.slot     = tail.hit_idx;
            cmd.old_rank = tail.hit_rank;
            cmd.wr_value = op_put_reg;
        end else if (op_put_reg && (cap_eff != '0)) begin
            if (32'(occ_reg) >= 32'(cap_eff)) begin
                // replace the victim in place; ages as a touch of its old rank
                if (tail.vic_ok) begin
                    res_ev       = 1'b1;
                    res_ev_key   = tail.vic_key;
                    cmd.en       = fire;
                    cmd.slot     = tail.vic_idx;
                    cmd.old_rank = tail.vic_rank;
                    cmd.load     = 1'b1;
                end
            end else if (tail.free_ok) begin
                occ_inc       = 1'b1;
                cmd.en        = fire;
                cmd.slot      = tail.free_idx;
                cmd.shift_all = 1'b1;
                cmd.load      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            cap_reg      <= CAP_RESET;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            // a new result in the same cycle keeps tvalid up
            if (m_tvalid_reg && m_tready && !fire) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_put_reg   <= s_tuser[0];
                        op_key_reg   <= s_tdata[31:0];
                        op_value_reg <= s_tdata[63:32];
                        scan_cnt_reg <= '0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == IDX_W'(ENTRIES - 1)) begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    if (fire) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {res_ev_key, res_read};
                        m_tuser_reg  <= {res_ev, res_hit};
                        if (occ_inc) begin
                            occ_reg <= occ_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks
    `ASSERT_CLK(a_occ_bound, occ_reg <= OCC_W'(ENTRIES), "occupancy beyond store size")
    `ASSERT_CLK(a_ev_not_hit, m_tvalid |-> !(m_tuser[0] && m_tuser[1]), "hit and evict together")
    `ASSERT_CLK(a_one_at_time, (s_tvalid && s_tready) |=> !s_tready, "item taken while busy")
    `ASSERT_ALWAYS(a_upd_in_apply, cmd.en |-> (state_reg == ST_APPLY), "update outside apply")

endmodule
